// ===== hdl/alc_pkg.sv =====
// alc_pkg: payload types, constants and the divide-by-255 helper for the
// layer alpha compositor; no dependencies
package alc_pkg;

   localparam int CHAN_W       = 8;
   localparam int PIXEL_W      = 32;
   localparam int COUNT_W      = 4;
   localparam int SUM_W        = 17;
   localparam int LAYER_INPUTS = 9;

   localparam logic [CHAN_W-1:0]  PAPER_LEVEL = 8'hFF;
   localparam logic [CHAN_W-1:0]  FULL_ALPHA  = 8'hFF;
   localparam logic [COUNT_W-1:0] COUNT_RESET = 4'd2;

   typedef struct packed {
      logic [PIXEL_W-1:0] layer1_pixel;
      logic [PIXEL_W-1:0] layer2_pixel;
      logic [PIXEL_W-1:0] layer3_pixel;
      logic [PIXEL_W-1:0] layer4_pixel;
      logic [PIXEL_W-1:0] layer5_pixel;
      logic [PIXEL_W-1:0] layer6_pixel;
      logic [PIXEL_W-1:0] layer7_pixel;
      logic [PIXEL_W-1:0] layer8_pixel;
      logic [PIXEL_W-1:0] layer9_pixel;
   } req_payload_type;

   typedef struct packed {
      logic [CHAN_W-1:0] out_red;
      logic [CHAN_W-1:0] out_green;
      logic [CHAN_W-1:0] out_blue;
   } rsp_payload_type;

   // what travels down the layer chain with each pixel
   typedef struct packed {
      req_payload_type      pixels;
      logic [COUNT_W-1:0]   count;
      rsp_payload_type      color;
   } pipe_item_type;

   function automatic logic [PIXEL_W-1:0] layer_pixel(input req_payload_type p,
                                                      input int idx);
      logic [PIXEL_W-1:0] px;
      case (idx)
         1:       px = p.layer1_pixel;
         2:       px = p.layer2_pixel;
         3:       px = p.layer3_pixel;
         4:       px = p.layer4_pixel;
         5:       px = p.layer5_pixel;
         6:       px = p.layer6_pixel;
         7:       px = p.layer7_pixel;
         8:       px = p.layer8_pixel;
         9:       px = p.layer9_pixel;
         default: px = '0;
      endcase
      return px;
   endfunction

   // floor(x/255), exact for x up to 255*255
   function automatic logic [CHAN_W-1:0] div255(input logic [SUM_W-1:0] x);
      logic [SUM_W-1:0] t;
      t = x + SUM_W'(1) + SUM_W'(x[SUM_W-1:8]);
      return t[15:8];
   endfunction

endpackage

// ===== hdl/layer_alpha_compositor_unit.sv =====
// layer alpha compositor: an entry register, then one layer stage per slot 1 to LAYER_SLOTS-1;
// throughput one pixel per cycle; each layer owns two register stages of the chain.
// busy is never raised and results cannot be held off by the receiver.
// synchronous active-high reset clears the valid bits and sets the active layer total to 2.
// depends on alc_pkg and alc_layer_stage
module layer_alpha_compositor_unit import alc_pkg::*; #(
   parameter int LAYER_SLOTS = 10
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  req_payload_type    req_payload,
   output logic               rsp_strobe,
   output rsp_payload_type    rsp_payload,
   input  logic               csr_we,
   input  logic [COUNT_W-1:0] csr_wdata
);

   localparam int LATENCY = 1 + 2 * (LAYER_SLOTS - 1);

   logic [COUNT_W-1:0] active_layers_ff;
   logic               accept;
   logic               stage_valid [LAYER_SLOTS];
   pipe_item_type      stage_item  [LAYER_SLOTS];
   logic               entry_valid_ff;
   pipe_item_type      entry_item_ff;
   pipe_item_type      entry_item_in;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_layers_ff <= COUNT_RESET;
      end else if (csr_we) begin
         active_layers_ff <= csr_wdata;
      end
   end

   // every pixel starts on opaque white paper
   always_comb begin
      entry_item_in.pixels          = req_payload;
      entry_item_in.count           = active_layers_ff;
      entry_item_in.color.out_red   = PAPER_LEVEL;
      entry_item_in.color.out_green = PAPER_LEVEL;
      entry_item_in.color.out_blue  = PAPER_LEVEL;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= 1'b0;
      end else begin
         entry_valid_ff <= accept;
      end
      entry_item_ff <= entry_item_in;
   end

   assign stage_valid[0] = entry_valid_ff;
   assign stage_item[0]  = entry_item_ff;

   for (genvar l = 1; l < LAYER_SLOTS; l++) begin : g_layer
      alc_layer_stage #(
         .SLOT_NUM (l)
      ) u_layer (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stage_valid[l-1]),
         .in_item   (stage_item[l-1]),
         .out_valid (stage_valid[l]),
         .out_item  (stage_item[l])
      );
   end

   assign rsp_strobe  = stage_valid[LAYER_SLOTS-1];
   assign rsp_payload = stage_item[LAYER_SLOTS-1].color;

   // every result strobe goes back to an accepted input transfer
   a_strobe_has_source: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, LATENCY))
      else $error("result strobe without a matching input transfer");

   // with no layer above the paper the result stays white
   a_paper_only_white: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && $past(accept && (active_layers_ff < COUNT_W'(2)), LATENCY)) |->
      (rsp_payload.out_red == PAPER_LEVEL && rsp_payload.out_green == PAPER_LEVEL &&
       rsp_payload.out_blue == PAPER_LEVEL))
      else $error("paper-only pixel is not white");

endmodule

// ===== hdl/alc_layer_stage.sv =====
// alc_layer_stage: one layer of the compositing chain, two register stages
// (weighted sums, then divide by 255); depends on alc_pkg
module alc_layer_stage import alc_pkg::*; #(
   parameter int SLOT_NUM = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   input  pipe_item_type in_item,
   output logic          out_valid,
   output pipe_item_type out_item
);

   logic [PIXEL_W-1:0] px;
   logic [CHAN_W-1:0]  alpha;
   logic [CHAN_W-1:0]  inv_alpha;
   logic [SUM_W-1:0]   sum_r_in, sum_g_in, sum_b_in;
   logic [SUM_W-1:0]   sum_r_ff, sum_g_ff, sum_b_ff;
   logic               valid_a_ff;
   req_payload_type    pixels_a_ff;
   logic [COUNT_W-1:0] count_a_ff;
   logic               valid_b_ff;
   pipe_item_type      item_b_ff;
   pipe_item_type      item_b_in;

   // a layer outside the count blends with alpha 0, which leaves the color as is
   always_comb begin
      px        = layer_pixel(in_item.pixels, SLOT_NUM);
      alpha     = (COUNT_W'(SLOT_NUM) < in_item.count) ? px[31:24] : '0;
      inv_alpha = FULL_ALPHA - alpha;
      sum_r_in  = SUM_W'(px[7:0]) * SUM_W'(alpha)
                + SUM_W'(in_item.color.out_red) * SUM_W'(inv_alpha);
      sum_g_in  = SUM_W'(px[15:8]) * SUM_W'(alpha)
                + SUM_W'(in_item.color.out_green) * SUM_W'(inv_alpha);
      sum_b_in  = SUM_W'(px[23:16]) * SUM_W'(alpha)
                + SUM_W'(in_item.color.out_blue) * SUM_W'(inv_alpha);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
      end else begin
         valid_a_ff <= in_valid;
      end
      sum_r_ff    <= sum_r_in;
      sum_g_ff    <= sum_g_in;
      sum_b_ff    <= sum_b_in;
      pixels_a_ff <= in_item.pixels;
      count_a_ff  <= in_item.count;
   end

   always_comb begin
      item_b_in.pixels          = pixels_a_ff;
      item_b_in.count           = count_a_ff;
      item_b_in.color.out_red   = div255(sum_r_ff);
      item_b_in.color.out_green = div255(sum_g_ff);
      item_b_in.color.out_blue  = div255(sum_b_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_b_ff <= 1'b0;
      end else begin
         valid_b_ff <= valid_a_ff;
      end
      item_b_ff <= item_b_in;
   end

   assign out_valid = valid_b_ff;
   assign out_item  = item_b_ff;

endmodule

// ===== dv/tb_layer_alpha_compositor_unit.sv =====
`timescale 1ns / 100ps
// testbench for layer_alpha_compositor_unit: random and directed pixel stacks,
// checked against a scoreboard that composites the layers over white paper.
// depends on alc_pkg and the compositor RTL
module tb_layer_alpha_compositor_unit;
   import alc_pkg::*;

   localparam int PIPE_LATENCY = 1 + 2 * (10 - 1);
   localparam int STALL_LIMIT  = 1000;
   localparam int REPORT_MAX   = 10;

   class composite_checker;
      logic [COUNT_W-1:0] active_layers;
      rsp_payload_type    expected_pixels[$];
      int                 mismatches;

      function new();
         active_layers = COUNT_RESET;
         mismatches    = 0;
      endfunction

      function automatic int unsigned mix(int unsigned src, int unsigned dst,
                                          int unsigned a);
         return (src * a + dst * (255 - a)) / 255;
      endfunction

      function automatic rsp_payload_type composite_pixel(req_payload_type p);
         logic [PIXEL_W-1:0] layers [1:9];
         int unsigned        limit;
         int unsigned        r, g, b, a;
         int unsigned        sr, sg, sb;
         rsp_payload_type    res;
         layers[1] = p.layer1_pixel;
         layers[2] = p.layer2_pixel;
         layers[3] = p.layer3_pixel;
         layers[4] = p.layer4_pixel;
         layers[5] = p.layer5_pixel;
         layers[6] = p.layer6_pixel;
         layers[7] = p.layer7_pixel;
         layers[8] = p.layer8_pixel;
         layers[9] = p.layer9_pixel;
         // counts above the slot count saturate
         limit = (active_layers > 10) ? 10 : 32'(active_layers);
         r = 255;
         g = 255;
         b = 255;
         for (int unsigned l = 1; l < limit; l++) begin
            a  = 32'(layers[l][31:24]);
            sr = 32'(layers[l][7:0]);
            sg = 32'(layers[l][15:8]);
            sb = 32'(layers[l][23:16]);
            if (a == 255) begin
               r = sr;
               g = sg;
               b = sb;
            end else if (a != 0) begin
               r = mix(sr, r, a);
               g = mix(sg, g, a);
               b = mix(sb, b, a);
            end
         end
         res.out_red   = r[7:0];
         res.out_green = g[7:0];
         res.out_blue  = b[7:0];
         return res;
      endfunction

      function void note_pixel(req_payload_type p);
         expected_pixels.insert(expected_pixels.size(), composite_pixel(p));
      endfunction

      function void check_result(rsp_payload_type got);
         rsp_payload_type want;
         if (expected_pixels.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display("%0t: unexpected result %h", $time, got);
            return;
         end
         want = expected_pixels.pop_front();
         if (got.out_red !== want.out_red || got.out_green !== want.out_green ||
             got.out_blue !== want.out_blue) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display("%0t: rgb expected %h %h %h, got %h %h %h", $time,
                        want.out_red, want.out_green, want.out_blue,
                        got.out_red, got.out_green, got.out_blue);
         end
      endfunction

      function int pending();
         return expected_pixels.size();
      endfunction
   endclass

   logic               clock       = 1'b0;
   logic               reset       = 1'b1;
   logic               start       = 1'b0;
   logic               busy;
   req_payload_type    req_payload = '0;
   logic               rsp_strobe;
   rsp_payload_type    rsp_payload;
   logic               csr_we      = 1'b0;
   logic [COUNT_W-1:0] csr_wdata   = '0;

   composite_checker   board       = new();
   bit                 sender_gaps = 1'b1;
   int                 stall_cycles = 0;

   layer_alpha_compositor_unit dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_strobe)
         board.check_result(rsp_payload);
   end

   function automatic logic [PIXEL_W-1:0] random_layer(logic [CHAN_W-1:0] a_hint,
                                                      bit use_hint);
      logic [PIXEL_W-1:0] px;
      px = $urandom;
      if (use_hint)
         px[31:24] = a_hint;
      else begin
         case ($urandom_range(3))
            0:       px[31:24] = 8'h00;
            1:       px[31:24] = FULL_ALPHA;
            default: px[31:24] = 8'($urandom_range(255));
         endcase
      end
      return px;
   endfunction

   function automatic req_payload_type random_stack();
      req_payload_type p;
      p.layer1_pixel = random_layer(8'h00, 1'b0);
      p.layer2_pixel = random_layer(8'h00, 1'b0);
      p.layer3_pixel = random_layer(8'h00, 1'b0);
      p.layer4_pixel = random_layer(8'h00, 1'b0);
      p.layer5_pixel = random_layer(8'h00, 1'b0);
      p.layer6_pixel = random_layer(8'h00, 1'b0);
      p.layer7_pixel = random_layer(8'h00, 1'b0);
      p.layer8_pixel = random_layer(8'h00, 1'b0);
      p.layer9_pixel = random_layer(8'h00, 1'b0);
      return p;
   endfunction

   function automatic req_payload_type uniform_stack(logic [PIXEL_W-1:0] px);
      req_payload_type p;
      p = {LAYER_INPUTS{px}};
      return p;
   endfunction

   task automatic send_pixel(req_payload_type p);
      while (sender_gaps && $urandom_range(99) < 38) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start       <= 1'b1;
      req_payload <= p;
      do
         @(posedge clock);
      while (busy);
      board.note_pixel(p);
   endtask

   // hold off until every result is back and the chain has emptied
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (board.pending() > 0)
         @(posedge clock);
      repeat (PIPE_LATENCY) @(posedge clock);
   endtask

   task automatic write_active_layers(logic [COUNT_W-1:0] value);
      drain();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      board.active_layers = value;
   endtask

   task automatic random_phase(logic [COUNT_W-1:0] count, int items);
      write_active_layers(count);
      for (int i = 0; i < items; i++)
         send_pixel(random_stack());
   endtask

   initial begin : watchdog
      while (stall_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((start && !busy) || rsp_strobe || reset)
            stall_cycles = 0;
         else
            stall_cycles++;
      end
      $display("Mismatches found");
      $finish;
   end

   initial begin : stimulus
      req_payload_type p;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset count of two: only layer 1 counts
      p = random_stack();
      p.layer1_pixel = 32'hFF10_2030;
      send_pixel(p);
      p.layer1_pixel = 32'h00AB_CDEF;
      send_pixel(p);
      p = uniform_stack(32'hFF00_0000);
      p.layer1_pixel = 32'h8000_0000;
      send_pixel(p);

      write_active_layers(4'd10);
      send_pixel(uniform_stack(32'h0000_0000));
      send_pixel(uniform_stack(32'hFFFF_FFFF));
      send_pixel(uniform_stack(32'hFF00_0000));
      send_pixel(uniform_stack(32'h0100_0000));
      send_pixel(uniform_stack(32'hFE00_0000));
      send_pixel(uniform_stack(32'h80FF_FFFF));
      send_pixel(uniform_stack(32'h7F12_34AB));
      p = uniform_stack(32'h0000_0000);
      p.layer1_pixel = 32'hFF00_00FF;
      send_pixel(p);
      p = random_stack();
      p.layer9_pixel = 32'hFF56_3412;
      send_pixel(p);
      p = uniform_stack(32'hFFFF_FFFF);
      p.layer9_pixel = 32'h0100_0000;
      send_pixel(p);
      p.layer9_pixel = 32'hFE00_0000;
      send_pixel(p);

      // counts of zero and one leave white paper
      write_active_layers(4'd0);
      send_pixel(uniform_stack(32'hFF00_0000));
      write_active_layers(4'd1);
      send_pixel(uniform_stack(32'hFF00_0000));
      // counts beyond the slots saturate
      write_active_layers(4'd15);
      send_pixel(uniform_stack(32'h8040_80C0));
      write_active_layers(4'd9);
      p = uniform_stack(32'h8040_80C0);
      p.layer9_pixel = 32'hFF00_0000;
      send_pixel(p);

      // back-to-back transfers with no sender gaps for a long stretch
      write_active_layers(4'd10);
      for (int i = 0; i < 300; i++) begin
         sender_gaps = (i < 80);
         send_pixel(random_stack());
      end
      sender_gaps = 1'b1;
      random_phase(4'd15, 150);
      random_phase(4'd4, 150);
      random_phase(4'd0, 50);
      random_phase(4'd1, 50);
      for (int k = 0; k < 8; k++)
         random_phase(COUNT_W'($urandom_range(15)), 56);

      drain();
      if (board.mismatches == 0 && board.pending() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
